// ----- src/wvmu_pkg.sv -----
// ----------------------------------------------------------------------------
// wvmu_pkg: shared types and constants
// Payload structs, load/compute codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none
package wvmu_pkg;

  localparam int DEF_MAX_SAMPLES    = 64;
  localparam int DEF_MAX_PREDICTORS = 16;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 31;

  localparam logic [2:0] KIND_Y        = 3'd0;
  localparam logic [2:0] KIND_X        = 3'd1;
  localparam logic [2:0] KIND_W        = 3'd2;
  localparam logic [2:0] KIND_VAR      = 3'd3;
  localparam logic [2:0] KIND_MU       = 3'd4;
  localparam logic [2:0] KIND_ALPHA    = 3'd5;
  localparam logic [2:0] KIND_COMPUTE  = 3'd6;
  // spare code, dropped by the block
  localparam logic [2:0] KIND_NONE     = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREDICTORS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_NOISE  = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         out_row;
    logic [3:0]         out_col;
    logic signed [31:0] new_mean;
    logic               last;
  } out_item_t;

  // floor(v / 2^16) on a 64-bit product
  function automatic logic signed [63:0] shr16(input logic signed [63:0] v);
    shr16 = v >>> 16;
  endfunction

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/weighted_variational_mean_update_core.sv -----
// ----------------------------------------------------------------------------
// weighted_variational_mean_update_core
// Loads y, x, w, variance, mean and inclusion elements; a compute transaction
// recomputes one row of the mean matrix with one shared multiplier.
// ----------------------------------------------------------------------------
// channel   | signals                          | handshake
// command   | start, busy, cmd                 | taken when start & !busy
// result    | result_valid, result             | one cycle, no stall
// config    | cfg_we, cfg_index, cfg_data      | written when cfg_we
//
// A load is written when it is accepted. A compute of row l forms the
// mean*alpha terms, then the row sums, then the new means of the row;
// every product goes through the single registered 32x32 multiplier, with
// each memory read registered ahead of it. busy stays high for the whole
// compute. Reset is synchronous; the stores hold garbage until loaded. The
// row-sum scratch is rewritten before it is read in every compute.
// ----------------------------------------------------------------------------
`default_nettype none
module weighted_variational_mean_update_core
  import wvmu_pkg::*;
#(
  parameter int MAX_SAMPLES    = DEF_MAX_SAMPLES,
  parameter int MAX_PREDICTORS = DEF_MAX_PREDICTORS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              cmd,
  output logic                       result_valid,
  output out_item_t                  result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW  = $clog2(MAX_SAMPLES);
  localparam int PW  = (MAX_PREDICTORS > 1) ? $clog2(MAX_PREDICTORS) : 1;
  localparam int MD  = MAX_SAMPLES * MAX_PREDICTORS;
  localparam int MAW = $clog2(MD);
  localparam int WD  = MAX_SAMPLES * MAX_SAMPLES;
  localparam int WAW = $clog2(WD);
  localparam int NW  = $clog2(MAX_SAMPLES + 1);
  localparam int PCW = $clog2(MAX_PREDICTORS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MA_RD, S_MA_MUL, S_MA_WR, S_RS_RD, S_RS_MUL, S_RS_ACC,
    S_AC_RD, S_AC_WX, S_AC_T, S_AC_R, S_AC_ACC,
    S_SV_RD, S_SV_MUL, S_SV_SAT, S_NM_MUL, S_NM_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [6:0]  samples_used;
  logic [4:0]  predictors_used;
  logic [30:0] inv_noise_variance;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_used       <= 7'd64;
      predictors_used    <= 5'd16;
      inv_noise_variance <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLES:    samples_used       <= cfg_data[6:0];
        REG_PREDICTORS: predictors_used    <= cfg_data[4:0];
        REG_INV_NOISE:  inv_noise_variance <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective counts clamped to 1..max
  logic [NW-1:0]  n_eff;
  logic [PCW-1:0] p_eff;
  always_comb begin
    if (samples_used == 7'd0) n_eff = NW'(1);
    else if (32'(samples_used) > MAX_SAMPLES) n_eff = NW'(MAX_SAMPLES);
    else n_eff = NW'(samples_used);
    if (predictors_used == 5'd0) p_eff = PCW'(1);
    else if (32'(predictors_used) > MAX_PREDICTORS) p_eff = PCW'(MAX_PREDICTORS);
    else p_eff = PCW'(predictors_used);
  end

  // sequencer registers
  logic [SW-1:0]      row_l;
  logic [SW-1:0]      idx_i;
  logic [PW-1:0]      idx_k;
  logic [PW-1:0]      idx_m;
  logic signed [31:0] ma [MAX_PREDICTORS];
  logic signed [63:0] sum;
  logic signed [31:0] wx;
  logic signed [31:0] rr;
  logic signed [31:0] sv;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;
  logic               x_is_row;

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // load decode
  logic     accept;
  logic     ld_ok_mat;
  logic [MAW-1:0] ld_maddr;
  assign accept    = start && !busy;
  assign ld_ok_mat = (32'(cmd.row_index) < MAX_SAMPLES) &&
                     (32'(cmd.col_index) < MAX_PREDICTORS);
  assign ld_maddr  = MAW'(32'(cmd.row_index) * MAX_PREDICTORS + 32'(cmd.col_index));

  // memory read addresses
  logic [MAW-1:0] x_raddr, l_raddr, mu_waddr;
  logic [WAW-1:0] w_raddr;
  assign x_raddr = MAW'(32'(idx_i) * MAX_PREDICTORS +
                        32'(x_is_row ? idx_m : idx_k));
  assign l_raddr = MAW'(32'(row_l) * MAX_PREDICTORS + 32'(state == S_MA_RD ||
                        state == S_MA_MUL ? idx_m : idx_k));
  assign w_raddr = WAW'(32'(idx_i) * MAX_SAMPLES + 32'(row_l));

  logic [31:0] y_q, x_q, w_q, var_q, mu_q, al_q;
  logic [63:0] rs_q;
  logic        mu_we, rs_we;
  logic [31:0] mu_wdata;
  logic signed [63:0] rs_wdata;
  logic [SW-1:0] rs_waddr;

  wvmu_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_y (
    .clk(clk), .we(accept && cmd.kind == KIND_Y && 32'(cmd.row_index) < MAX_SAMPLES),
    .waddr(SW'(cmd.row_index)), .wdata(cmd.value), .raddr(idx_i), .rdata(y_q));
  wvmu_ram #(.WIDTH(32), .DEPTH(MD)) u_x (
    .clk(clk), .we(accept && cmd.kind == KIND_X && ld_ok_mat),
    .waddr(ld_maddr), .wdata(cmd.value), .raddr(x_raddr), .rdata(x_q));
  wvmu_ram #(.WIDTH(32), .DEPTH(WD)) u_w (
    .clk(clk), .we(accept && cmd.kind == KIND_W &&
                   32'(cmd.row_index) < MAX_SAMPLES && 32'(cmd.col_index) < MAX_SAMPLES),
    .waddr(WAW'(32'(cmd.row_index) * MAX_SAMPLES + 32'(cmd.col_index))),
    .wdata(cmd.value), .raddr(w_raddr), .rdata(w_q));
  wvmu_ram #(.WIDTH(32), .DEPTH(MD)) u_var (
    .clk(clk), .we(accept && cmd.kind == KIND_VAR && ld_ok_mat),
    .waddr(ld_maddr), .wdata(cmd.value), .raddr(l_raddr), .rdata(var_q));
  wvmu_ram #(.WIDTH(32), .DEPTH(MD)) u_mu (
    .clk(clk), .we(mu_we), .waddr(mu_waddr), .wdata(mu_wdata),
    .raddr(l_raddr), .rdata(mu_q));
  wvmu_ram #(.WIDTH(32), .DEPTH(MD)) u_al (
    .clk(clk), .we(accept && cmd.kind == KIND_ALPHA && ld_ok_mat),
    .waddr(ld_maddr), .wdata(cmd.value), .raddr(l_raddr), .rdata(al_q));
  wvmu_ram #(.WIDTH(64), .DEPTH(MAX_SAMPLES)) u_rs (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(idx_i), .rdata(rs_q));

  // mean store: loads while idle, write-back of results while busy
  logic signed [31:0] nm;
  assign nm       = sat32(shr16(prod));
  assign mu_we    = (accept && cmd.kind == KIND_MU && ld_ok_mat) || state == S_NM_OUT;
  assign mu_waddr = (state == S_NM_OUT) ?
                    MAW'(32'(row_l) * MAX_PREDICTORS + 32'(idx_k)) : ld_maddr;
  assign mu_wdata = (state == S_NM_OUT) ? nm : cmd.value;
  assign rs_we    = (state == S_RS_ACC) && (32'(idx_m) + 1 == 32'(p_eff));
  assign rs_waddr = idx_i;
  assign rs_wdata = sum + shr16(prod);

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_MA_MUL: begin op_a = mu_q;  op_b = al_q; end
      S_RS_MUL: begin op_a = x_q;   op_b = ma[idx_m]; end
      S_AC_WX:  begin op_a = w_q;   op_b = x_q; end
      S_AC_T:   begin op_a = x_q;   op_b = ma[idx_k]; end
      S_AC_ACC: begin op_a = wx;    op_b = rr; end
      S_SV_MUL: begin op_a = var_q; op_b = $signed({1'b0, inv_noise_variance}); end
      S_NM_MUL: begin op_a = sat32(sum); op_b = sv; end
      default: ;
    endcase
  end

  // sequencer and registered outputs
  logic i_last, k_last, m_last;
  assign i_last = (32'(idx_i) + 1 == 32'(n_eff));
  assign k_last = (32'(idx_k) + 1 == 32'(p_eff));
  assign m_last = (32'(idx_m) + 1 == 32'(p_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy         <= 1'b0;
      result_valid <= 1'b0;
      x_is_row     <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && cmd.kind == KIND_COMPUTE && 32'(cmd.row_index) < 32'(n_eff)) begin
            row_l    <= SW'(cmd.row_index);
            idx_m    <= '0;
            idx_i    <= '0;
            idx_k    <= '0;
            busy     <= 1'b1;
            state    <= S_MA_RD;
          end
        end
        S_MA_RD: state <= S_MA_MUL;
        S_MA_MUL: state <= S_MA_WR;
        S_MA_WR: begin
          ma[idx_m] <= sat32(shr16(prod));
          if (m_last) begin
            idx_m    <= '0;
            x_is_row <= 1'b1;
            sum      <= '0;
            state    <= S_RS_RD;
          end else begin
            idx_m <= idx_m + 1'b1;
            state <= S_MA_RD;
          end
        end
        S_RS_RD: state <= S_RS_MUL;
        S_RS_MUL: state <= S_RS_ACC;
        S_RS_ACC: begin
          if (m_last) begin
            sum   <= '0;
            idx_m <= '0;
            if (i_last) begin
              idx_i    <= '0;
              x_is_row <= 1'b0;
              state    <= S_AC_RD;
            end else begin
              idx_i <= idx_i + 1'b1;
              state <= S_RS_RD;
            end
          end else begin
            sum   <= sum + shr16(prod);
            idx_m <= idx_m + 1'b1;
            state <= S_RS_RD;
          end
        end
        S_AC_RD: begin
          // fold in the previous sample's term
          if (idx_i != '0) sum <= sum + shr16(prod);
          state <= S_AC_WX;
        end
        S_AC_WX: state <= S_AC_T;
        S_AC_T: begin
          wx    <= sat32(shr16(prod));
          state <= S_AC_R;
        end
        S_AC_R: begin
          rr    <= sat32($signed({{32{y_q[31]}}, y_q}) - $signed(rs_q) + shr16(prod));
          state <= S_AC_ACC;
        end
        S_AC_ACC: begin
          state <= (i_last) ? S_SV_RD : S_AC_RD;
          if (!i_last) idx_i <= idx_i + 1'b1;
        end
        S_SV_RD: begin
          sum   <= sum + shr16(prod);
          state <= S_SV_MUL;
        end
        S_SV_MUL: state <= S_SV_SAT;
        S_SV_SAT: begin
          sv    <= sat32(shr16(prod));
          state <= S_NM_MUL;
        end
        S_NM_MUL: state <= S_NM_OUT;
        S_NM_OUT: begin
          // product of sat32(acc) * sv is ready now
          result_valid    <= 1'b1;
          result.out_row  <= 6'(row_l);
          result.out_col  <= 4'(idx_k);
          result.new_mean <= nm;
          result.last     <= k_last;
          sum             <= '0;
          idx_i           <= '0;
          if (k_last) begin
            busy  <= 1'b0;
            state <= S_IDLE;
          end else begin
            idx_k <= idx_k + 1'b1;
            state <= S_AC_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // every result belongs to a compute that was busy when it was issued
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without compute");
  // last result ends the compute
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy) else $error("busy after last");
  // idle state implies busy is low
  a_idle_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !busy) else $error("busy while idle");
`endif

endmodule
`default_nettype wire

// ----- src/wvmu_ram.sv -----
// ----------------------------------------------------------------------------
// wvmu_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module wvmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
